@@ sv/bayer_quad_bin_normalize_top_defines.svh @@
// Assertion helpers shared by the queue and back-end modules.
`ifndef BAYER_QUAD_BIN_NORMALIZE_TOP_DEFINES_SVH
`define BAYER_QUAD_BIN_NORMALIZE_TOP_DEFINES_SVH

// Same-cycle implication.
`define BQBN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BQBN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bqbn_pkg.sv @@
`timescale 1ns / 1ps
package bqbn_pkg;

    localparam int CFG_BITS      = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [CFG_BITS-1:0] BLACK_RESET = 16'h0000;
    localparam logic [CFG_BITS-1:0] WHITE_RESET = 16'hFFFF;

    localparam logic REG_BLACK_LEVEL = 1'b0;
    localparam logic REG_WHITE_LEVEL = 1'b1;

    localparam int N_LANES    = 3;
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    localparam int CLS_BITS = 2;

    typedef enum logic [CLS_BITS-1:0] {
        CLS_ZERO,
        CLS_ONE,
        CLS_DIV
    } t_lane_cls;

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

endpackage

@@ sv/bqbn_if.sv @@
`timescale 1ns / 1ps
interface bqbn_quad_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] red_sample;
    logic [SAMPLE_BITS-1:0] green_a_sample;
    logic [SAMPLE_BITS-1:0] green_b_sample;
    logic [SAMPLE_BITS-1:0] blue_sample;

    modport source (
        output valid, red_sample, green_a_sample, green_b_sample, blue_sample,
        input  ready
    );
    modport sink (
        input  valid, red_sample, green_a_sample, green_b_sample, blue_sample,
        output ready
    );
endinterface

interface bqbn_pix_if #(
    parameter int FRAC_BITS = 16
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] red_level;
    logic [FRAC_BITS:0] green_level;
    logic [FRAC_BITS:0] blue_level;
    logic               range_error;

    modport source (
        output valid, red_level, green_level, blue_level, range_error,
        input  ready
    );
    modport sink (
        input  valid, red_level, green_level, blue_level, range_error,
        output ready
    );
endinterface

@@ sv/bqbn_front.sv @@
`timescale 1ns / 1ps
module bqbn_front #(
    parameter  int SAMPLE_BITS = 16,
    localparam int D           = SAMPLE_BITS + 1,
    localparam int JOB_W       = 1 + SAMPLE_BITS + bqbn_pkg::N_LANES * (bqbn_pkg::CLS_BITS + D)
) (
    input  logic [SAMPLE_BITS-1:0] i_black,
    input  logic [SAMPLE_BITS-1:0] i_white,
    input  logic [SAMPLE_BITS-1:0] i_red,
    input  logic [SAMPLE_BITS-1:0] i_green_a,
    input  logic [SAMPLE_BITS-1:0] i_green_b,
    input  logic [SAMPLE_BITS-1:0] i_blue,
    output logic [JOB_W-1:0]       o_job
);

    typedef struct packed {
        bqbn_pkg::t_lane_cls cls;
        logic [D-1:0]        num;
    } t_lane;

    typedef struct packed {
        logic                          err;
        logic [SAMPLE_BITS-1:0]        range;
        t_lane [bqbn_pkg::N_LANES-1:0] lane;
    } t_job;

    function automatic t_lane classify(logic [D-1:0] num, logic below, logic [D-1:0] den,
                                       logic bad);
        t_lane res;
        res.num = num;
        if (bad || below || num == '0) begin
            res.cls = bqbn_pkg::CLS_ZERO;
        end else if (num >= den) begin
            res.cls = bqbn_pkg::CLS_ONE;
        end else begin
            res.cls = bqbn_pkg::CLS_DIV;
        end
        return res;
    endfunction

    logic                   bad;
    logic [SAMPLE_BITS-1:0] rng;
    logic [D-1:0]           rng_d;
    logic [D-1:0]           rng2;
    logic [D-1:0]           red_num;
    logic [D-1:0]           blue_num;
    logic [D-1:0]           gsum;
    logic [D-1:0]           gblk;
    logic [D-1:0]           gnum;
    t_job                   job;

    assign bad      = (i_white <= i_black);
    assign rng      = i_white - i_black;
    assign rng_d    = D'(rng);
    assign rng2     = {rng, 1'b0};
    assign red_num  = D'(i_red) - D'(i_black);
    assign blue_num = D'(i_blue) - D'(i_black);
    assign gsum     = D'(i_green_a) + D'(i_green_b);
    assign gblk     = {i_black, 1'b0};
    assign gnum     = gsum - gblk;

    always_comb begin
        job.err   = bad;
        job.range = rng;
        job.lane[bqbn_pkg::LANE_RED]   = classify(red_num, i_red < i_black, rng_d, bad);
        job.lane[bqbn_pkg::LANE_GREEN] = classify(gnum, gsum < gblk, rng2, bad);
        job.lane[bqbn_pkg::LANE_BLUE]  = classify(blue_num, i_blue < i_black, rng_d, bad);
    end

    assign o_job = job;

endmodule

@@ sv/bqbn_queue.sv @@
`timescale 1ns / 1ps
`include "bayer_quad_bin_normalize_top_defines.svh"
module bqbn_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]                r_mem [bqbn_pkg::Q_DEPTH];
    logic [bqbn_pkg::QPTR_W-1:0]     r_wr;
    logic [bqbn_pkg::QPTR_W-1:0]     r_rd;
    logic [bqbn_pkg::QCNT_W-1:0]     r_cnt;
    logic [bqbn_pkg::QPTR_W-1:0]     n_wr;
    logic [bqbn_pkg::QPTR_W-1:0]     n_rd;
    logic [bqbn_pkg::QCNT_W-1:0]     n_cnt;

    localparam logic [bqbn_pkg::QPTR_W-1:0] LAST = bqbn_pkg::QPTR_W'(bqbn_pkg::Q_DEPTH - 1);
    localparam logic [bqbn_pkg::QCNT_W-1:0] FULL = bqbn_pkg::QCNT_W'(bqbn_pkg::Q_DEPTH);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full = (r_cnt == FULL);
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rd];

    `BQBN_ASSERT_NOW(a_que_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= FULL, "queue count over depth")
    `BQBN_ASSERT_NOW(a_que_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0, "pop from empty queue")
    `BQBN_ASSERT_NEXT(a_que_grow, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "queue count did not grow")

endmodule

@@ sv/bqbn_back.sv @@
`timescale 1ns / 1ps
`include "bayer_quad_bin_normalize_top_defines.svh"
module bqbn_back #(
    parameter  int SAMPLE_BITS = 16,
    parameter  int FRAC_BITS   = 16,
    localparam int D           = SAMPLE_BITS + 1,
    localparam int JOB_W       = 1 + SAMPLE_BITS + bqbn_pkg::N_LANES * (bqbn_pkg::CLS_BITS + D)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_vld,
    input  logic [JOB_W-1:0]   i_q_job,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FRAC_BITS:0] o_red_level,
    output logic [FRAC_BITS:0] o_green_level,
    output logic [FRAC_BITS:0] o_blue_level,
    output logic               o_range_error
);

    typedef struct packed {
        bqbn_pkg::t_lane_cls cls;
        logic [D-1:0]        num;
    } t_lane;

    typedef struct packed {
        logic                          err;
        logic [SAMPLE_BITS-1:0]        range;
        t_lane [bqbn_pkg::N_LANES-1:0] lane;
    } t_job;

    localparam int NL = bqbn_pkg::N_LANES;

    function automatic logic [FRAC_BITS:0] compose(bqbn_pkg::t_lane_cls cls,
                                                   logic [FRAC_BITS-1:0] quo);
        logic [FRAC_BITS:0] lvl;
        unique case (cls)
            bqbn_pkg::CLS_ONE: lvl = {1'b1, {FRAC_BITS{1'b0}}};
            bqbn_pkg::CLS_DIV: lvl = {1'b0, quo};
            default:           lvl = '0;
        endcase
        return lvl;
    endfunction

    t_job                   job;
    logic                   en;

    logic                   r_vld   [0:FRAC_BITS];
    logic                   r_err   [0:FRAC_BITS];
    logic [SAMPLE_BITS-1:0] r_range [0:FRAC_BITS];
    bqbn_pkg::t_lane_cls    r_cls   [0:FRAC_BITS][NL];
    logic [D-1:0]           r_rem   [0:FRAC_BITS][NL];
    logic [FRAC_BITS-1:0]   r_quo   [0:FRAC_BITS][NL];

    logic [D-1:0]           n_rem   [1:FRAC_BITS][NL];
    logic [FRAC_BITS-1:0]   n_quo   [1:FRAC_BITS][NL];

    logic                   r_out_vld;
    logic                   r_out_err;
    logic [FRAC_BITS:0]     r_out_lvl [NL];

    assign job     = i_q_job;
    assign en      = !r_out_vld || i_ready;
    assign o_q_pop = en && i_q_vld;

    // One quotient bit per stage: restoring step on each lane.
    always_comb begin
        logic [D-1:0] den;
        logic [D:0]   rem2;
        logic         ge;
        for (int s = 1; s <= FRAC_BITS; s++) begin
            for (int l = 0; l < NL; l++) begin
                den  = (l == bqbn_pkg::LANE_GREEN) ? {r_range[s-1], 1'b0}
                                                   : {1'b0, r_range[s-1]};
                rem2 = {r_rem[s-1][l], 1'b0};
                ge   = (rem2 >= {1'b0, den});
                n_rem[s][l] = ge ? D'(rem2 - {1'b0, den}) : D'(rem2);
                n_quo[s][l] = {r_quo[s-1][l][FRAC_BITS-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= FRAC_BITS; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_q_vld;
            for (int s = 1; s <= FRAC_BITS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_err[0]   <= job.err;
            r_range[0] <= job.range;
            for (int l = 0; l < NL; l++) begin
                r_cls[0][l] <= job.lane[l].cls;
                r_rem[0][l] <= job.lane[l].num;
                r_quo[0][l] <= '0;
            end
            for (int s = 1; s <= FRAC_BITS; s++) begin
                r_err[s]   <= r_err[s-1];
                r_range[s] <= r_range[s-1];
                for (int l = 0; l < NL; l++) begin
                    r_cls[s][l] <= r_cls[s-1][l];
                    r_rem[s][l] <= n_rem[s][l];
                    r_quo[s][l] <= n_quo[s][l];
                end
            end
            r_out_err <= r_err[FRAC_BITS];
            for (int l = 0; l < NL; l++) begin
                r_out_lvl[l] <= compose(r_cls[FRAC_BITS][l], r_quo[FRAC_BITS][l]);
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_range_error = r_out_err;
    assign o_red_level   = r_out_lvl[bqbn_pkg::LANE_RED];
    assign o_green_level = r_out_lvl[bqbn_pkg::LANE_GREEN];
    assign o_blue_level  = r_out_lvl[bqbn_pkg::LANE_BLUE];

    `BQBN_ASSERT_NOW(a_bck_err_zero, i_clk, i_rst_n, r_out_vld && r_out_err, (r_out_lvl[0] == '0) && (r_out_lvl[1] == '0) && (r_out_lvl[2] == '0), "range error with nonzero level")
    `BQBN_ASSERT_NEXT(a_bck_stall_hold, i_clk, i_rst_n, !en, $stable(r_vld[FRAC_BITS]), "pipeline moved while stalled")
    `BQBN_ASSERT_NEXT(a_bck_no_loss, i_clk, i_rst_n, en && r_vld[FRAC_BITS], r_out_vld, "result dropped at output")

endmodule

@@ sv/bayer_quad_bin_normalize_top.sv @@
`timescale 1ns / 1ps
// Bayer 2x2 quad binning with black/white level normalization.
// i_quad (sink): one RGGB quad per item; accepted when valid && ready.
// o_pix (source): one Q1.FRAC_BITS RGB pixel per item plus range_error,
//   taken when valid && ready. Items leave in the order they arrived.
// APB port: black_level at 0x0, white_level at 0x4, both 16 bits, no wait
//   states. Write only while no item is in flight.
// Pipeline: the queue, one load stage, FRAC_BITS divider stages and one
//   output register. Throughput: one item per cycle unless o_pix stalls.
// The divider is a pipeline of FRAC_BITS restoring steps, one quotient
//   bit per stage, three lanes in parallel.
// Output stall: the back pipeline freezes; a 4-entry queue keeps taking
//   items until full, then i_quad.ready drops.
// Reset (synchronous, active low): pipeline and queue empty, black level 0,
//   white level all ones.
module bayer_quad_bin_normalize_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bqbn_quad_if.sink                           i_quad,
    bqbn_pix_if.source                          o_pix,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bqbn_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [bqbn_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [bqbn_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int D     = SAMPLE_BITS + 1;
    localparam int JOB_W = 1 + SAMPLE_BITS + bqbn_pkg::N_LANES * (bqbn_pkg::CLS_BITS + D);

    logic [bqbn_pkg::CFG_BITS-1:0] r_black_level;
    logic [bqbn_pkg::CFG_BITS-1:0] r_white_level;
    logic                          cfg_wr;
    logic                          reg_idx;

    logic [JOB_W-1:0] front_job;
    logic [JOB_W-1:0] q_job;
    logic             q_full;
    logic             q_vld;
    logic             q_pop;
    logic             push;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_level <= bqbn_pkg::BLACK_RESET;
            r_white_level <= bqbn_pkg::WHITE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bqbn_pkg::REG_BLACK_LEVEL: r_black_level <= pwdata[bqbn_pkg::CFG_BITS-1:0];
                bqbn_pkg::REG_WHITE_LEVEL: r_white_level <= pwdata[bqbn_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bqbn_pkg::REG_BLACK_LEVEL: prdata = bqbn_pkg::APB_DATA_BITS'(r_black_level);
            bqbn_pkg::REG_WHITE_LEVEL: prdata = bqbn_pkg::APB_DATA_BITS'(r_white_level);
            default:                   prdata = '0;
        endcase
    end

    assign i_quad.ready = !q_full;
    assign push         = i_quad.valid && !q_full;

    bqbn_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_black   (r_black_level[SAMPLE_BITS-1:0]),
        .i_white   (r_white_level[SAMPLE_BITS-1:0]),
        .i_red     (i_quad.red_sample),
        .i_green_a (i_quad.green_a_sample),
        .i_green_b (i_quad.green_b_sample),
        .i_blue    (i_quad.blue_sample),
        .o_job     (front_job)
    );

    bqbn_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_job)
    );

    bqbn_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_vld       (q_vld),
        .i_q_job       (q_job),
        .o_q_pop       (q_pop),
        .o_valid       (o_pix.valid),
        .i_ready       (o_pix.ready),
        .o_red_level   (o_pix.red_level),
        .o_green_level (o_pix.green_level),
        .o_blue_level  (o_pix.blue_level),
        .o_range_error (o_pix.range_error)
    );

endmodule

@@ verif/tb_bayer_quad_bin_normalize_top.sv @@
`timescale 1ns / 1ps
module tb_bayer_quad_bin_normalize_top;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = FRAC_BITS + 6;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [FRAC_BITS:0] ONE_LEVEL = {1'b1, {FRAC_BITS{1'b0}}};

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [FRAC_BITS:0]     t_level;

    typedef struct packed {
        t_sample red;
        t_sample green_a;
        t_sample green_b;
        t_sample blue;
    } t_raw_quad;

    typedef struct packed {
        t_level red;
        t_level green;
        t_level blue;
        logic   range_err;
    } t_rgb_pixel;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [bqbn_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [bqbn_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [bqbn_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    bqbn_quad_if #(.SAMPLE_BITS(SAMPLE_BITS)) quad_bus ();
    bqbn_pix_if  #(.FRAC_BITS(FRAC_BITS))     pix_bus ();

    bayer_quad_bin_normalize_top #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_quad (quad_bus),
        .o_pix  (pix_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    logic [bqbn_pkg::CFG_BITS-1:0] black_lvl;
    logic [bqbn_pkg::CFG_BITS-1:0] white_lvl;
    t_rgb_pixel          expected_pixels[$];
    int                  mismatches    = 0;
    int                  tx_idle_pct   = 0;
    int                  rx_idle_pct   = 0;
    int                  rx_hold_cycles = 0;
    int                  quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    // output side: random ready, or a long hold-off on request
    initial begin
        pix_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                pix_bus.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else begin
                pix_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_level scaled_level(longint unsigned num, longint unsigned den);
        if (num == 0) return '0;
        if (num >= den) return ONE_LEVEL;
        return t_level'((num << FRAC_BITS) / den);
    endfunction

    function automatic t_rgb_pixel normalize_quad(t_raw_quad q);
        t_rgb_pixel      px;
        longint unsigned span;
        longint unsigned gsum;
        longint unsigned gblack;
        px = '0;
        if (white_lvl <= black_lvl) begin
            px.range_err = 1'b1;
            return px;
        end
        span   = longint'(white_lvl) - longint'(black_lvl);
        gsum   = longint'(q.green_a) + longint'(q.green_b);
        gblack = 2 * longint'(black_lvl);
        px.red   = scaled_level((q.red < black_lvl) ? 0 : q.red - black_lvl, span);
        px.blue  = scaled_level((q.blue < black_lvl) ? 0 : q.blue - black_lvl, span);
        px.green = scaled_level((gsum < gblack) ? 0 : gsum - gblack, 2 * span);
        return px;
    endfunction

    task automatic check_field(input string field, input t_level want, input t_level got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pixel: expected none, actual r=%0d g=%0d b=%0d e=%0b",
                         $time, pix_bus.red_level, pix_bus.green_level, pix_bus.blue_level,
                         pix_bus.range_error);
            end else begin
                want = expected_pixels.pop_front();
                check_field("red_level", want.red, pix_bus.red_level);
                check_field("green_level", want.green, pix_bus.green_level);
                check_field("blue_level", want.blue, pix_bus.blue_level);
                check_field("range_error", t_level'(want.range_err),
                            t_level'(pix_bus.range_error));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (quad_bus.valid && quad_bus.ready)
            || (pix_bus.valid && pix_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d pixels outstanding", $time, expected_pixels.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic check_level(input logic reg_sel);
        logic [bqbn_pkg::CFG_BITS-1:0] want;
        want = (reg_sel == bqbn_pkg::REG_BLACK_LEVEL) ? black_lvl : white_lvl;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[bqbn_pkg::CFG_BITS-1:0] !== want) begin
            mismatches++;
            $display("%0t: readback of register %0d: expected %0d, actual %0d",
                     $time, reg_sel, want, prdata[bqbn_pkg::CFG_BITS-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_level(input logic reg_sel, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        // upper bits carry junk, the register keeps only its own width
        pwdata  <= {(bqbn_pkg::APB_DATA_BITS-bqbn_pkg::CFG_BITS)'($urandom),
                    value[bqbn_pkg::CFG_BITS-1:0]};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == bqbn_pkg::REG_BLACK_LEVEL) black_lvl = value[bqbn_pkg::CFG_BITS-1:0];
        else white_lvl = value[bqbn_pkg::CFG_BITS-1:0];
        @(posedge i_clk);
        check_level(reg_sel);
    endtask

    task automatic set_levels(input int black, input int white);
        set_level(bqbn_pkg::REG_BLACK_LEVEL, black);
        set_level(bqbn_pkg::REG_WHITE_LEVEL, white);
    endtask

    task automatic offer_quad(input t_sample r, input t_sample ga, input t_sample gb,
                              input t_sample b);
        t_raw_quad q;
        q = {r, ga, gb, b};
        while ($urandom_range(99) < tx_idle_pct) begin
            quad_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        quad_bus.valid          <= 1'b1;
        quad_bus.red_sample     <= r;
        quad_bus.green_a_sample <= ga;
        quad_bus.green_b_sample <= gb;
        quad_bus.blue_sample    <= b;
        @(posedge i_clk);
        while (!quad_bus.ready) @(posedge i_clk);
        expected_pixels.insert(expected_pixels.size(), normalize_quad(q));
    endtask

    task automatic wait_drained();
        quad_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_sample clamp_sample(int v);
        if (v < 0) return '0;
        if (v > 65535) return '1;
        return t_sample'(v);
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(5))
            2: return clamp_sample(int'(black_lvl) + int'($urandom_range(6)) - 3);
            3: return clamp_sample(int'(white_lvl) + int'($urandom_range(6)) - 3);
            4: begin
                if (white_lvl > black_lvl)
                    return clamp_sample(int'(black_lvl)
                                        + int'($urandom_range(int'(white_lvl - black_lvl))));
                return t_sample'($urandom);
            end
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic offer_random_quad();
        t_sample r;
        t_sample ga;
        t_sample gb;
        t_sample b;
        r  = pick_sample();
        ga = pick_sample();
        b  = pick_sample();
        // green pair straddling twice the black level
        if ($urandom_range(5) == 0)
            gb = clamp_sample(2 * int'(black_lvl) - int'(ga) + int'($urandom_range(2)) - 1);
        else
            gb = pick_sample();
        offer_quad(r, ga, gb, b);
    endtask

    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        check_level(bqbn_pkg::REG_BLACK_LEVEL);
        check_level(bqbn_pkg::REG_WHITE_LEVEL);
        offer_quad(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        offer_quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_quad(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        offer_quad(16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE);
        offer_quad(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        wait_drained();
        set_levels(4096, 8192);
        // below black, green sum exactly at twice black, at black
        offer_quad(16'd4095, 16'd4095, 16'd4097, 16'd4096);
        // at white, just under white
        offer_quad(16'd8192, 16'd8192, 16'd8192, 16'd8191);
        // above white, greens one high one low
        offer_quad(16'hFFFF, 16'hFFFF, 16'h0000, 16'd8193);
        offer_quad(16'd6144, 16'd4095, 16'd4098, 16'd5000);
        wait_drained();
        set_levels(65534, 65535);
        offer_quad(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFD);
        wait_drained();
        set_levels(1000, 1000);
        offer_quad(16'd2000, 16'd500, 16'hFFFF, 16'd1000);
        wait_drained();
        set_levels(65535, 0);
        offer_quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int items_per_setting);
        int black;
        int white;
        int n_items;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < 5; k++) begin
            n_items = items_per_setting;
            case (k)
                0: begin
                    black = 0;
                    white = 65535;
                end
                1: begin
                    black = $urandom_range(4095);
                    white = $urandom_range(65535, black + 1);
                end
                2: begin
                    case ($urandom_range(2))
                        0: black = 0;
                        1: black = 65534;
                        default: black = $urandom_range(65532);
                    endcase
                    white = black + 1 + ((black < 65532) ? $urandom_range(2) : 0);
                end
                3: begin
                    black = $urandom_range(60000, 1024);
                    white = $urandom_range(65535, black + 1);
                end
                default: begin
                    white   = $urandom_range(65535);
                    black   = $urandom_range(65535, white);
                    n_items = items_per_setting / 3;
                end
            endcase
            set_levels(black, white);
            repeat (n_items) offer_random_quad();
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_levels($urandom_range(2047), 61000);
        rx_hold_cycles = HOLD_CYCLES;
        repeat (60) offer_random_quad();
        // sender pauses until the block has emptied, then resumes
        wait_drained();
        repeat (30) offer_random_quad();
        wait_drained();
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        quad_bus.valid          = 1'b0;
        quad_bus.red_sample     = '0;
        quad_bus.green_a_sample = '0;
        quad_bus.green_b_sample = '0;
        quad_bus.blue_sample    = '0;
        black_lvl               = bqbn_pkg::BLACK_RESET;
        white_lvl               = bqbn_pkg::WHITE_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(37, 79, 100);
        test_random_traffic(79, 37, 100);
        test_random_traffic(0, 0, 100);
        test_backpressure();

        repeat (LATENCY) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/bqbn_pkg.sv
sv/bqbn_if.sv
sv/bqbn_front.sv
sv/bqbn_queue.sv
sv/bqbn_back.sv
sv/bayer_quad_bin_normalize_top.sv
verif/tb_bayer_quad_bin_normalize_top.sv
